@@ hw/rtl/ezr_pkg.sv @@
// package for the euler zyx vector rotator
// holds payload structs, trig constants and the cordic arctangent table
package ezr_pkg;

	localparam int TrigBits    = 18;
	localparam int TrigOne     = 65536;
	localparam int CordicSteps = 24;
	localparam int CordicW     = 36;
	localparam int CompBits    = 24;

	typedef logic signed [TrigBits-1:0] trig_t;
	typedef logic [1:0] reg_idx_t;

	localparam reg_idx_t RegYaw   = 2'd0;
	localparam reg_idx_t RegPitch = 2'd1;
	localparam reg_idx_t RegRoll  = 2'd2;

	typedef struct packed {
		logic                        op;
		logic signed [CompBits-1:0] in_x;
		logic signed [CompBits-1:0] in_y;
		logic signed [CompBits-1:0] in_z;
	} in_item_t;

	typedef struct packed {
		logic signed [CompBits-1:0] out_x;
		logic signed [CompBits-1:0] out_y;
		logic signed [CompBits-1:0] out_z;
		logic                        saturated;
	} out_item_t;

	typedef struct packed {
		logic [1:0] idx;
		logic       busy;
	} trig_status_t;

	// arctangent table, 2^31 = pi
	function automatic logic signed [CordicW-1:0] atan_lut(input logic [4:0] i);
		unique case (i)
			5'd0:  atan_lut = 36'sd536870912;
			5'd1:  atan_lut = 36'sd316933406;
			5'd2:  atan_lut = 36'sd167458907;
			5'd3:  atan_lut = 36'sd85004756;
			5'd4:  atan_lut = 36'sd42667331;
			5'd5:  atan_lut = 36'sd21354465;
			5'd6:  atan_lut = 36'sd10679838;
			5'd7:  atan_lut = 36'sd5340245;
			5'd8:  atan_lut = 36'sd2670163;
			5'd9:  atan_lut = 36'sd1335087;
			5'd10: atan_lut = 36'sd667544;
			5'd11: atan_lut = 36'sd333772;
			5'd12: atan_lut = 36'sd166886;
			5'd13: atan_lut = 36'sd83443;
			5'd14: atan_lut = 36'sd41722;
			5'd15: atan_lut = 36'sd20861;
			5'd16: atan_lut = 36'sd10430;
			5'd17: atan_lut = 36'sd5215;
			5'd18: atan_lut = 36'sd2608;
			5'd19: atan_lut = 36'sd1304;
			5'd20: atan_lut = 36'sd652;
			5'd21: atan_lut = 36'sd326;
			5'd22: atan_lut = 36'sd163;
			5'd23: atan_lut = 36'sd81;
			default: atan_lut = '0;
		endcase
	endfunction

endpackage

@@ hw/rtl/ezr_cordic.sv @@
// iterative cordic: one rotation step per cycle, produces cos and sin in q1.16
// depends on ezr_pkg
module ezr_cordic #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ANGLE_BITS-1:0]         angle,
	output logic                          busy,
	output logic                          done,
	output ezr_pkg::trig_t                cos_o,
	output ezr_pkg::trig_t                sin_o
);
	import ezr_pkg::*;

	localparam logic signed [CordicW-1:0] GainQ30 = 36'sd652032874;

	logic signed [CordicW-1:0] x_q, y_q, z_q;
	logic [4:0]                step_q;
	logic                      neg_q;
	logic [31:0]               a_scaled;
	logic [31:0]               a_fold;
	logic                      fold;
	logic signed [CordicW-1:0] dx, dy, atn;
	logic signed [CordicW-1:0] xr, yr;
	trig_t                     c_rnd, s_rnd;

	// scale to 32 bits and fold into the right half plane
	assign a_scaled = {angle, {(32-ANGLE_BITS){1'b0}}};
	assign fold     = a_scaled[31] ^ a_scaled[30];
	assign a_fold   = fold ? (a_scaled ^ 32'h8000_0000) : a_scaled;

	assign dx  = y_q >>> step_q;
	assign dy  = x_q >>> step_q;
	assign atn = atan_lut(step_q);

	// iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy   <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy   <= 1'b1;
				step_q <= '0;
			end else if (busy) begin
				if (step_q == 5'(CordicSteps-1)) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
				step_q <= step_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= GainQ30;
			y_q   <= '0;
			z_q   <= CordicW'(signed'(a_fold));
			neg_q <= fold;
		end else if (busy) begin
			if (!z_q[CordicW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atn;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atn;
			end
		end
	end

	// round to q1.16 and clamp
	function automatic trig_t rnd(input logic signed [CordicW-1:0] v);
		logic signed [CordicW-1:0] r;
		r = (v + 36'sd8192) >>> 14;
		if (r > TrigOne) rnd = trig_t'(TrigOne);
		else if (r < -TrigOne) rnd = trig_t'(-TrigOne);
		else rnd = trig_t'(r);
	endfunction

	assign xr    = x_q;
	assign yr    = y_q;
	assign c_rnd = rnd(xr);
	assign s_rnd = rnd(yr);
	assign cos_o = neg_q ? -c_rnd : c_rnd;
	assign sin_o = neg_q ? -s_rnd : s_rnd;

endmodule

@@ hw/rtl/ezr_trig_regs.sv @@
// angle registers and trig cache, refreshed through a shared cordic
// depends on ezr_pkg and ezr_cordic
module ezr_trig_regs #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [ANGLE_BITS-1:0] cfg_data,
	output ezr_pkg::trig_status_t status,
	output ezr_pkg::trig_t        cy,
	output ezr_pkg::trig_t        sy,
	output ezr_pkg::trig_t        cp,
	output ezr_pkg::trig_t        sp,
	output ezr_pkg::trig_t        cr,
	output ezr_pkg::trig_t        sr
);
	import ezr_pkg::*;

	logic       busy, done, start;
	logic       pend;
	logic [1:0] idx_q;
	trig_t      c_new, s_new;

	// update pending from the cfg transfer until the cache is written back
	assign pend      = busy || done;
	assign cfg_ready = !pend;
	assign start     = cfg_valid && cfg_ready && (cfg_index <= RegRoll);
	assign status    = '{idx: idx_q, busy: pend};

	ezr_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(start), .angle(cfg_data),
		.busy(busy), .done(done), .cos_o(c_new), .sin_o(s_new)
	);

	// latch target and write back the finished pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= RegYaw;
			cy <= trig_t'(TrigOne); sy <= '0;
			cp <= trig_t'(TrigOne); sp <= '0;
			cr <= trig_t'(TrigOne); sr <= '0;
		end else begin
			if (start) idx_q <= cfg_index;
			if (done) begin
				unique case (idx_q)
					RegYaw:   begin cy <= c_new; sy <= s_new; end
					RegPitch: begin cp <= c_new; sp <= s_new; end
					default:  begin cr <= c_new; sr <= s_new; end
				endcase
			end
		end
	end

endmodule

@@ hw/rtl/ezr_rot_stage.sv @@
// one planar rotation stage: two rounded product sums, registered
// depends on ezr_pkg
module ezr_rot_stage (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vld_in,
	input  logic                    op_in,
	input  logic signed [26:0]      a_in,
	input  logic signed [26:0]      b_in,
	input  logic signed [26:0]      c_in,
	input  ezr_pkg::trig_t          cs,
	input  ezr_pkg::trig_t          sn,
	output logic                    vld_out,
	output logic                    op_out,
	output logic signed [26:0]      a_out,
	output logic signed [26:0]      b_out,
	output logic signed [26:0]      c_out
);
	import ezr_pkg::*;

	// rotates (a,b) by the angle, c passes; a' = c*a - s*b, b' = c*b + s*a
	logic signed [46:0] pa, pb;
	assign pa = (47'(cs) * 47'(a_in) - 47'(sn) * 47'(b_in) + 47'sd32768) >>> 16;
	assign pb = (47'(cs) * 47'(b_in) + 47'(sn) * 47'(a_in) + 47'sd32768) >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_out <= 1'b0;
		else if (en) vld_out <= vld_in;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_out <= op_in;
			a_out  <= 27'(pa);
			b_out  <= 27'(pb);
			c_out  <= c_in;
		end
	end

endmodule

@@ hw/rtl/euler_zyx_vector_rotator_unit.sv @@
// euler zyx vector rotator: top level
// depends on ezr_pkg, ezr_trig_regs, ezr_rot_stage
//
// Usage
// - in channel (in_valid/in_ready/in_data): op plus a q7.16 vector; op 0
//   applies roll, pitch, yaw, op 1 applies the inverse in reverse order
// - out channel (out_valid/out_ready/out_data): rotated vector, saturated,
//   with a flag when any component clipped
// - cfg channel: index 0 yaw, 1 pitch, 2 roll; higher indexes are dropped.
//   each write to index 0, 1 or 2 runs a 24-step cordic; cfg_ready and in_ready
//   are low until the new pair sits in the trig cache
// - throughput: one transfer per cycle while the output is not stalled and no
//   trig update is pending; an item passes three registered rotation stages
//   and a saturation register before out_valid rises for it
// - the pipeline advances whenever the output register is empty or taken,
//   so a stalled receiver freezes every stage in place without loss
// - reset clears the valid bits and sets the trig cache to zero angles
module euler_zyx_vector_rotator_unit #(
	parameter int ANGLE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ezr_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output ezr_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [ANGLE_BITS-1:0] cfg_data
);
	import ezr_pkg::*;

	trig_status_t       st;
	trig_t              cy, sy, cp, sp, cr, sr;
	logic               en;
	logic               v1, v2, v3, o1, o2, o3;
	logic signed [26:0] a1, b1, c1, a2, b2, c2, a3, b3, c3;
	logic signed [26:0] ix, iy, iz;
	trig_t              t1c, t1s, t2c, t2s, t3c, t3s;
	logic signed [26:0] i1a, i1b, i2a, i2b, i2c, i3a, i3b, i3c;
	logic signed [26:0] rx, ry, rz;
	logic               cx, cyc, cz;

	// hold new items back while the output is stalled or a trig update is pending
	assign en       = !out_valid || out_ready;
	assign in_ready = en && !st.busy;

	ezr_trig_regs #(.ANGLE_BITS(ANGLE_BITS)) u_trig (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .status(st),
		.cy(cy), .sy(sy), .cp(cp), .sp(sp), .cr(cr), .sr(sr)
	);

	assign ix = 27'(in_data.in_x);
	assign iy = 27'(in_data.in_y);
	assign iz = 27'(in_data.in_z);

	// stage 1: forward roll on (y,z), backward -yaw on (x,y) as (y,x)
	assign t1c = in_data.op ? cy : cr;
	assign t1s = in_data.op ? sy : sr;
	assign i1a = in_data.op ? iy : iy;
	assign i1b = in_data.op ? ix : iz;
	ezr_rot_stage u_s1 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(in_valid && in_ready),
		.op_in(in_data.op), .a_in(i1a), .b_in(i1b),
		.c_in(in_data.op ? iz : ix), .cs(t1c), .sn(t1s),
		.vld_out(v1), .op_out(o1), .a_out(a1), .b_out(b1), .c_out(c1)
	);
	// after s1: fwd a1=y', b1=z', c1=x; bwd a1=y', b1=x', c1=z
	// note backward uses y' = c*y - s*x and x' = c*x + s*y: matches (a,b)=(y,x)

	// stage 2: pitch; fwd rotates (z,x): z'=c*z - s*x, x'=c*x + s*z
	//          bwd rotates (x,z) with -pitch: x'=c*x - s*z, z'=c*z + s*x
	assign t2c = cp;
	assign t2s = sp;
	assign i2a = o1 ? b1 : b1;
	assign i2b = o1 ? c1 : c1;
	assign i2c = a1;
	ezr_rot_stage u_s2 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(v1), .op_in(o1),
		.a_in(i2a), .b_in(i2b), .c_in(i2c), .cs(t2c), .sn(t2s),
		.vld_out(v2), .op_out(o2), .a_out(a2), .b_out(b2), .c_out(c2)
	);
	// after s2: fwd a2=z'', b2=x'', c2=y'; bwd a2=x'', b2=z'', c2=y'

	// stage 3: fwd yaw on (x,y): x=c*x - s*y, y=c*y + s*x
	//          bwd -roll on (z,y): z=c*z - s*y, y=c*y + s*z
	assign t3c = o2 ? cr : cy;
	assign t3s = o2 ? sr : sy;
	assign i3a = b2;
	assign i3b = c2;
	assign i3c = a2;
	ezr_rot_stage u_s3 (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(v2), .op_in(o2),
		.a_in(i3a), .b_in(i3b), .c_in(i3c), .cs(t3c), .sn(t3s),
		.vld_out(v3), .op_out(o3), .a_out(a3), .b_out(b3), .c_out(c3)
	);
	// after s3: fwd a3=x, b3=y, c3=z; bwd a3=z, b3=y, c3=x

	assign rx = o3 ? c3 : a3;
	assign ry = b3;
	assign rz = o3 ? a3 : c3;

	function automatic logic signed [CompBits-1:0] sat(input logic signed [26:0] v,
			output logic clip);
		logic signed [26:0] hi, lo;
		hi = 27'sd8388607;
		lo = -27'sd8388608;
		clip = 1'b0;
		sat  = v[CompBits-1:0];
		if (v > hi) begin sat = hi[CompBits-1:0]; clip = 1'b1; end
		if (v < lo) begin sat = lo[CompBits-1:0]; clip = 1'b1; end
	endfunction

	// output register with saturation
	logic signed [CompBits-1:0] sx, sy_v, sz;
	always_comb begin
		sx   = sat(rx, cx);
		sy_v = sat(ry, cyc);
		sz   = sat(rz, cz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.out_x     <= sx;
			out_data.out_y     <= sy_v;
			out_data.out_z     <= sz;
			out_data.saturated <= cx | cyc | cz;
		end
	end

	// checks
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st.busy |-> !cfg_ready) else $error("cfg ready while cordic busy");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output lost during stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !st.busy |-> in_ready) else $error("input blocked with empty output");

endmodule

@@ tb/euler_zyx_vector_rotator_unit_tb.sv @@
// testbench for the euler zyx vector rotator: directed table plus random vectors
// checked against an in-bench fixed-point predictor; depends on ezr_pkg and the rtl
module euler_zyx_vector_rotator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ezr_pkg::*;

	localparam int MaxC = (1 << 23) - 1;
	localparam int MinC = -(1 << 23);
	localparam int Latency = 4;
	localparam int WatchLimit = 400;
	localparam logic OpFwd = 1'b0;
	localparam logic OpBwd = 1'b1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	always #1 clk = ~clk;

	euler_zyx_vector_rotator_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state: cos/sin of yaw, pitch, roll
	longint trig_c[3];
	longint trig_s[3];
	out_item_t rotated_q[$];
	int errors = 0;
	int n_in = 0;
	int n_out = 0;
	int n_sat = 0;
	int idle_cycles = 0;
	int rx_wait = 0;
	bit stim_done = 1'b0;

	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	// cordic sine/cosine of a 16-bit binary angle
	function automatic void angle_trig(logic [15:0] ang, output longint c, output longint s);
		logic [31:0] a;
		longint x, y, z, dx, dy;
		longint atan_v[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
			10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722,
			20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
		bit neg;
		a = {ang, 16'h0};
		neg = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
		if (neg) a[31] = ~a[31];
		z = longint'(signed'(a));
		x = 652032874;
		y = 0;
		for (int i = 0; i < 24; i++) begin
			dx = fshift(y, i);
			dy = fshift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_v[i];
			end else begin
				x += dx; y -= dy; z += atan_v[i];
			end
		end
		c = fshift(x + 8192, 14);
		s = fshift(y + 8192, 14);
		if (c > 65536) c = 65536;
		if (c < -65536) c = -65536;
		if (s > 65536) s = 65536;
		if (s < -65536) s = -65536;
		if (neg) begin
			c = -c; s = -s;
		end
	endfunction

	function automatic longint mac2(longint c1, longint a, longint c2, longint b);
		return fshift(c1 * a + c2 * b + 32768, 16);
	endfunction

	function automatic logic [23:0] clamp24(longint v, inout logic clip);
		if (v > MaxC) begin v = MaxC; clip = 1'b1; end
		if (v < MinC) begin v = MinC; clip = 1'b1; end
		return v[23:0];
	endfunction

	function automatic out_item_t rotate_vector(in_item_t it);
		longint x, y, z, a1, a2, a3, b1, b2, b3, r1, r2, r3;
		longint cy, sy, cp, sp, cr, sr;
		out_item_t o;
		logic clip;
		cy = trig_c[RegYaw]; sy = trig_s[RegYaw];
		cp = trig_c[RegPitch]; sp = trig_s[RegPitch];
		cr = trig_c[RegRoll]; sr = trig_s[RegRoll];
		x = it.in_x; y = it.in_y; z = it.in_z;
		clip = 1'b0;
		if (it.op == OpFwd) begin
			a1 = x;
			a2 = mac2(cr, y, -sr, z);
			a3 = mac2(cr, z, sr, y);
			b1 = mac2(cp, a1, sp, a3);
			b2 = a2;
			b3 = mac2(cp, a3, -sp, a1);
			r1 = mac2(cy, b1, -sy, b2);
			r2 = mac2(cy, b2, sy, b1);
			r3 = b3;
		end else begin
			a1 = mac2(cy, x, sy, y);
			a2 = mac2(cy, y, -sy, x);
			a3 = z;
			b1 = mac2(cp, a1, -sp, a3);
			b2 = a2;
			b3 = mac2(cp, a3, sp, a1);
			r1 = b1;
			r2 = mac2(cr, b2, sr, b3);
			r3 = mac2(cr, b3, -sr, b2);
		end
		o.out_x = clamp24(r1, clip);
		o.out_y = clamp24(r2, clip);
		o.out_z = clamp24(r3, clip);
		o.saturated = clip;
		return o;
	endfunction

	// register write over the cfg channel, mirrored into the predictor
	task automatic write_angle(logic [1:0] idx, logic [15:0] ang);
		longint c, s;
		cfg_index <= idx;
		cfg_data <= ang;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx <= RegRoll) begin
			angle_trig(ang, c, s);
			trig_c[idx] = c;
			trig_s[idx] = s;
		end
		@(posedge clk);
	endtask

	// valid stays up after a transfer until the next item or an idle gap
	task automatic send_vector(in_item_t it, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		rotated_q.push_back(rotate_vector(it));
		n_in++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (rotated_q.size() != 0) @(posedge clk);
		repeat (Latency + 2) @(posedge clk);
	endtask

	function automatic in_item_t rand_vec(logic op, bit big);
		in_item_t it;
		it.op = op;
		if (big) begin
			it.in_x = 24'($urandom); it.in_y = 24'($urandom); it.in_z = 24'($urandom);
		end else begin
			it.in_x = 24'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			it.in_y = 24'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			it.in_z = 24'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		end
		return it;
	endfunction

	function automatic int gap_draw();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
	endfunction

	// receiver: per-transfer stall draw, compare each transfer against the oldest prediction
	always @(posedge clk) begin
		out_item_t exp_o;
		int w;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				n_out++;
				if (rotated_q.size() == 0) begin
					$error("unexpected result transfer %h", out_data);
					errors++;
				end else begin
					exp_o = rotated_q.pop_front();
					if (out_data.saturated) n_sat++;
					if (out_data.out_x !== exp_o.out_x) begin
						$error("out_x exp %0d got %0d", exp_o.out_x, out_data.out_x);
						errors++;
					end
					if (out_data.out_y !== exp_o.out_y) begin
						$error("out_y exp %0d got %0d", exp_o.out_y, out_data.out_y);
						errors++;
					end
					if (out_data.out_z !== exp_o.out_z) begin
						$error("out_z exp %0d got %0d", exp_o.out_z, out_data.out_z);
						errors++;
					end
					if (out_data.saturated !== exp_o.saturated) begin
						$error("saturated exp %0b got %0b", exp_o.saturated, out_data.saturated);
						errors++;
					end
				end
				w = gap_draw();
				out_ready <= (w == 0);
				rx_wait <= w;
			end else if (!out_ready) begin
				if (rx_wait <= 1) out_ready <= 1'b1;
				rx_wait <= rx_wait - 1;
			end
		end
	end

	// watchdog on cycles with no transfer of any kind, disarmed once stimulus is done
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
				|| stim_done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WatchLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	typedef struct {
		logic op;
		int x, y, z;
		bit has_exp;
		out_item_t exp_o;
	} dir_row_t;

	initial begin
		dir_row_t rows[$];
		in_item_t it;
		logic [15:0] ang_set[3];
		int k;
		int wait_cnt;
		for (int i = 0; i < 3; i++) begin
			trig_c[i] = 65536; trig_s[i] = 0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity after reset: results are read off directly
		rows.push_back('{OpFwd, 0, 0, 0, 1'b1, '{24'(0), 24'(0), 24'(0), 1'b0}});
		rows.push_back('{OpFwd, MaxC, MinC, MaxC, 1'b1,
			'{24'(MaxC), 24'(MinC), 24'(MaxC), 1'b0}});
		rows.push_back('{OpBwd, MinC, MaxC, MinC, 1'b1,
			'{24'(MinC), 24'(MaxC), 24'(MinC), 1'b0}});
		rows.push_back('{OpBwd, 1, -1, 65536, 1'b1, '{24'(1), 24'(-1), 24'(65536), 1'b0}});
		foreach (rows[i]) begin
			it = '{rows[i].op, 24'(rows[i].x), 24'(rows[i].y), 24'(rows[i].z)};
			if (rows[i].has_exp && rotate_vector(it) !== rows[i].exp_o) begin
				$error("directed row %0d table disagrees with predictor", i);
				errors++;
			end
			send_vector(it, 0);
		end
		drain();

		// extremes of each angle, plus an out-of-range index that is dropped
		write_angle(RegYaw, 16'h8000);
		write_angle(RegPitch, 16'h4000);
		write_angle(RegRoll, 16'h7fff);
		write_angle(2'd3, 16'h1234);
		foreach (rows[i])
			send_vector('{rows[i].op, 24'(rows[i].x), 24'(rows[i].y), 24'(rows[i].z)}, 0);
		send_vector('{OpFwd, 24'(MaxC), 24'(MaxC), 24'(MaxC)}, 0);
		send_vector('{OpBwd, 24'(MinC), 24'(MinC), 24'(MinC)}, 0);
		drain();
		write_angle(RegYaw, 16'h2000);
		write_angle(RegPitch, 16'hc000);
		write_angle(RegRoll, 16'he000);
		for (int i = 0; i < 8; i++) send_vector(rand_vec(i[0], i[1]), 0);
		drain();

		// random phases, each under a fresh angle set
		k = 0;
		for (int ph = 0; ph < 24; ph++) begin
			for (int j = 0; j < 3; j++) begin
				case ($urandom_range(0, 4))
					0: ang_set[j] = 16'h8000;
					1: ang_set[j] = 16'h7fff;
					2: ang_set[j] = 16'h0000;
					default: ang_set[j] = 16'($urandom);
				endcase
				write_angle(j[1:0], ang_set[j]);
			end
			for (int n = 0; n < 50; n++) begin
				send_vector(rand_vec(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0),
					(ph % 4 == 0) ? 0 : gap_draw());
				k++;
				// sender hold-off until everything has come back
				if (n == 25 && ph % 5 == 1) begin
					in_valid <= 1'b0;
					@(posedge clk);
					wait_cnt = 0;
					while (rotated_q.size() != 0 && wait_cnt < 5000) begin
						@(posedge clk);
						wait_cnt++;
					end
				end
			end
			drain();
		end

		stim_done = 1'b1;
		wait_cnt = 0;
		while (rotated_q.size() != 0 && wait_cnt < 5000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (Latency + 4) @(posedge clk);
		$display("covered %0d vectors over %0d random angle sets, both directions", n_in, 24);
		$display("%0d results compared, %0d of them clipped", n_out, n_sat);
		if (errors == 0 && rotated_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
